/* rtl/core/bps_pkg.sv */
// Shared types and constants for the byte pattern search block.
package bps_pkg;

    localparam int PAT_BYTES   = 32;
    localparam int PAT_W       = PAT_BYTES * 8;
    localparam int LEN_W       = 6;
    localparam int OFFSET_W    = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_PAT_LEN   = 3'd4,
        CFG_BASE      = 3'd5,
        CFG_SCAN_ALL  = 3'd6
    } bps_cfg_index_t;

    typedef enum logic {
        RESULT_MATCH = 1'b0,
        RESULT_END   = 1'b1
    } bps_kind_t;

    typedef struct packed {
        logic [PAT_W-1:0]    pattern;
        logic [LEN_W-1:0]    length;
        logic [OFFSET_W-1:0] base_offset;
        logic                scan_all;
    } bps_cfg_t;

    // One queue entry holds every result that a single item causes.
    typedef struct packed {
        logic                has_match;
        logic [OFFSET_W-1:0] match_offset;
        logic                has_end;
        logic                any_found;
    } bps_entry_t;

endpackage

/* rtl/core/bps_channels.sv */
// Handshake channel interfaces: input bytes, results and configuration writes.
interface bps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface bps_out_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [bps_pkg::OFFSET_W-1:0]  match_offset;
    logic                          any_found;
    logic                          run_last;

    modport source (output valid, output result_kind, output match_offset,
                    output any_found, output run_last, input ready);
    modport sink   (input valid, input result_kind, input match_offset,
                    input any_found, input run_last, output ready);
endinterface

interface bps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bps_pkg::CFG_INDEX_W-1:0] index;
    logic [bps_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bps_window.sv */
// Input stage, sliding byte window and parallel pattern compare.
module bps_window #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bps_pkg::bps_cfg_t    cfg,
    bps_in_if.sink               in_ch,
    input  logic                 q_room,
    output logic                 push,
    output bps_pkg::bps_entry_t  entry
);

    localparam int WIN     = MAX_PATTERN - 1;
    localparam int LEN_LIM = (MAX_PATTERN < bps_pkg::PAT_BYTES) ? MAX_PATTERN
                                                                : bps_pkg::PAT_BYTES;
    localparam int FILL_W  = $clog2(MAX_PATTERN);

    logic                          stage_valid_reg, stage_valid_next;
    logic [7:0]                    stage_byte_reg;
    logic                          stage_end_reg;

    logic [7:0]                    win_reg [WIN];
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic [bps_pkg::OFFSET_W-1:0]  seen_reg, seen_next;
    logic                          match_seen_reg, match_seen_next;

    logic [7:0]                    apat_reg [MAX_PATTERN];
    logic [7:0]                    apat_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]        mask_reg, mask_next;
    logic [bps_pkg::LEN_W-1:0]     len_reg, len_next;

    logic accept, advance, hit, seq_ok, fill_ok, report;

    // Effective length, and the pattern laid out newest-byte first.
    always_comb
    begin
        logic [bps_pkg::LEN_W-1:0] idx;
        idx = '0;
        if (cfg.length > bps_pkg::LEN_W'(LEN_LIM))
            len_next = bps_pkg::LEN_W'(LEN_LIM);
        else
            len_next = cfg.length;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i < int'(len_next))
            begin
                idx          = len_next - bps_pkg::LEN_W'(1) - bps_pkg::LEN_W'(i);
                apat_next[i] = cfg.pattern[{idx[4:0], 3'b000} +: 8];
                mask_next[i] = 1'b1;
            end
            else
            begin
                apat_next[i] = 8'h00;
                mask_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        mask_reg <= mask_next;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            apat_reg[i] <= apat_next[i];
        end
    end

    // Compare the staged byte and the window against the aligned pattern.
    always_comb
    begin
        seq_ok = 1'b1;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            if (mask_reg[i] && (win_reg[i-1] != apat_reg[i]))
                seq_ok = 1'b0;
        end
    end

    assign fill_ok = 7'(fill_reg) >= (7'(len_reg) - 7'd1);
    assign hit     = (len_reg != '0) && fill_ok && (stage_byte_reg == apat_reg[0]) && seq_ok;
    assign report  = hit && (cfg.scan_all || !match_seen_reg);

    assign advance     = stage_valid_reg && q_room;
    assign in_ch.ready = !stage_valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;

    assign push               = advance && (report || stage_end_reg);
    assign entry.has_match    = report;
    assign entry.match_offset = seen_reg - bps_pkg::OFFSET_W'(len_reg) + 32'd1
                                + cfg.base_offset;
    assign entry.has_end      = stage_end_reg;
    assign entry.any_found    = match_seen_reg || hit;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        fill_next        = fill_reg;
        seen_next        = seen_reg;
        match_seen_next  = match_seen_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        if (advance)
        begin
            if (stage_end_reg)
            begin
                fill_next       = '0;
                seen_next       = '0;
                match_seen_next = 1'b0;
            end
            else
            begin
                if (fill_reg != FILL_W'(WIN))
                    fill_next = fill_reg + FILL_W'(1);
                seen_next       = seen_reg + 32'd1;
                match_seen_next = match_seen_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            fill_reg        <= '0;
            seen_reg        <= '0;
            match_seen_reg  <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            fill_reg        <= fill_next;
            seen_reg        <= seen_next;
            match_seen_reg  <= match_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= in_ch.data_byte;
            stage_end_reg  <= in_ch.region_end;
        end
        if (advance)
        begin
            win_reg[0] <= stage_byte_reg;
            for (int k = 1; k < WIN; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

endmodule

/* rtl/core/bps_result_queue.sv */
// Two-entry result queue; splits an entry into its match and end items.
module bps_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bps_pkg::bps_entry_t  entry,
    output logic                 room,
    bps_out_if.source            out_ch
);

    bps_pkg::bps_entry_t               entries_reg [bps_pkg::QUEUE_DEPTH];
    logic [bps_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bps_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bps_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                              end_phase_reg, end_phase_next;

    bps_pkg::bps_entry_t head;
    logic                show_end, fire, pop;

    assign head     = entries_reg[rd_ptr_reg];
    assign room     = count_reg != bps_pkg::QUEUE_CNT_W'(bps_pkg::QUEUE_DEPTH);
    assign show_end = !head.has_match || end_phase_reg;
    assign fire     = out_ch.valid && out_ch.ready;
    assign pop      = fire && (show_end || !head.has_end);

    assign out_ch.valid        = count_reg != '0;
    assign out_ch.result_kind  = show_end ? logic'(bps_pkg::RESULT_END)
                                          : logic'(bps_pkg::RESULT_MATCH);
    assign out_ch.match_offset = show_end ? '0 : head.match_offset;
    assign out_ch.any_found    = show_end && head.any_found;
    assign out_ch.run_last     = show_end;

    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        end_phase_next = end_phase_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + bps_pkg::QUEUE_PTR_W'(1);
        if (pop)
        begin
            rd_ptr_next    = rd_ptr_reg + bps_pkg::QUEUE_PTR_W'(1);
            end_phase_next = 1'b0;
        end
        else if (fire)
            end_phase_next = 1'b1;
        if (push && !pop)
            count_next = count_reg + bps_pkg::QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - bps_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            end_phase_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            end_phase_reg <= end_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= entry;
    end

endmodule

/* rtl/core/byte_pattern_search.sv */
// Top level of the streaming byte pattern search block.
//
//  Channel  Dir  Payload                                        Accepted when
//  in_ch    in   data_byte[7:0], region_end                     valid && ready
//  out_ch   out  result_kind, match_offset[31:0], any_found,    valid && ready
//                run_last
//  cfg      in   index[2:0], data[63:0]                         valid && ready
//
// One byte per cycle while the queue has room: an accepted item sits in the
// input stage, where the window compare runs; its results enter a two-entry
// queue. A region's last byte that also completes a reported match gives two
// items, presented in turn on the output side; the queue stalls the input only
// when it is full. Reset sets the configuration registers (length one), the
// window fill count and the queue; the configuration port is always ready.
module byte_pattern_search #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    bps_in_if.sink     in_ch,
    bps_out_if.source  out_ch,
    bps_cfg_if.sink    cfg
);

    logic [bps_pkg::PAT_W-1:0]    pattern_reg;
    logic [bps_pkg::LEN_W-1:0]    length_reg;
    logic [bps_pkg::OFFSET_W-1:0] base_reg;
    logic                         scan_reg;

    bps_pkg::bps_cfg_t   cfg_bus;
    bps_pkg::bps_entry_t entry;
    logic                push, q_room;

    // Register writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= bps_pkg::LEN_W'(1);
            base_reg    <= '0;
            scan_reg    <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (bps_pkg::bps_cfg_index_t'(cfg.index))
                bps_pkg::CFG_PAT_0_7:   pattern_reg[0   +: 64] <= cfg.data;
                bps_pkg::CFG_PAT_8_15:  pattern_reg[64  +: 64] <= cfg.data;
                bps_pkg::CFG_PAT_16_23: pattern_reg[128 +: 64] <= cfg.data;
                bps_pkg::CFG_PAT_24_31: pattern_reg[192 +: 64] <= cfg.data;
                bps_pkg::CFG_PAT_LEN:   length_reg <= cfg.data[bps_pkg::LEN_W-1:0];
                bps_pkg::CFG_BASE:      base_reg   <= cfg.data[bps_pkg::OFFSET_W-1:0];
                bps_pkg::CFG_SCAN_ALL:  scan_reg   <= cfg.data[0];
                default:                ; // drop writes to unused indexes
            endcase
        end
    end

    assign cfg_bus.pattern     = pattern_reg;
    assign cfg_bus.length      = length_reg;
    assign cfg_bus.base_offset = base_reg;
    assign cfg_bus.scan_all    = scan_reg;

    // Input stage, window and compare.
    bps_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .in_ch  (in_ch),
        .q_room (q_room),
        .push   (push),
        .entry  (entry)
    );

    // Hold results until the sink takes them.
    bps_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .entry  (entry),
        .room   (q_room),
        .out_ch (out_ch)
    );

endmodule
